@@ rtl/core/paretoarc_pkg.sv @@
// Package: shared types, constants and compare helpers for the Pareto archive.
`timescale 1ns / 1ps
package paretoarc_pkg;
  localparam int CAPACITY = 32;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = 6;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    MODE_OFFER = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [2:0] ST_ACCEPT  = 3'd0;
  localparam logic [2:0] ST_REJECT  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_READOUT = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  // One queued command word between front and back.
  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] risk;
    logic signed [31:0] ret;
  } cmd_t;

  // Absolute difference within tolerance.
  function automatic logic near_eq(input logic signed [31:0] a,
                                   input logic signed [31:0] b,
                                   input logic [15:0] tol);
    logic signed [32:0] d;
    logic [32:0] m;
    begin
      d = 33'(a) - 33'(b);
      m = d[32] ? 33'(-d) : 33'(d);
      near_eq = m <= {17'd0, tol};
    end
  endfunction

  // Point a dominates point b.
  function automatic logic beats(input logic signed [31:0] ar,
                                 input logic signed [31:0] aret,
                                 input logic signed [31:0] br,
                                 input logic signed [31:0] bret,
                                 input logic [15:0] tol);
    logic br_ret, br_risk;
    begin
      br_ret = aret > bret;
      br_risk = ar < br;
      beats = (br_ret && (br_risk || near_eq(ar, br, tol))) ||
              (br_risk && (br_ret || near_eq(aret, bret, tol)));
    end
  endfunction
endpackage

@@ rtl/core/paretoarc_front.sv @@
// Front: accepts command words and queues them for the back end.
`timescale 1ns / 1ps
module paretoarc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode,
  input  logic signed [31:0]    candidate_risk,
  input  logic signed [31:0]    candidate_return,
  input  logic                  pop,
  output logic                  q_valid,
  output paretoarc_pkg::cmd_t   q_word
);
  paretoarc_pkg::cmd_t q [paretoarc_pkg::QDEPTH];
  logic       rd;
  logic       wr;
  logic [1:0] fill;
  logic       push;

  assign busy    = (fill == 2'(paretoarc_pkg::QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_word  = q[rd];

  // Hold words in a two-entry ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd   <= 1'b0;
      wr   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        q[wr] <= '{mode: paretoarc_pkg::mode_t'(mode),
                   risk: candidate_risk, ret: candidate_return};
        wr <= ~wr;
      end
      if (pop && q_valid) rd <= ~rd;
      fill <= fill + 2'(push) - 2'(pop && q_valid);
    end
  end
endmodule

@@ rtl/core/paretoarc_back.sv @@
// Back: scans, compacts and reads out the archive one entry per cycle.
`timescale 1ns / 1ps
module paretoarc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           tol,
  output logic                  idle,
  input  logic                  q_valid,
  input  paretoarc_pkg::cmd_t   q_word,
  output logic                  pop,
  output logic                  done,
  output logic [2:0]            status,
  output logic [5:0]            removed_count,
  output logic [5:0]            entry_count,
  output logic signed [31:0]    out_risk,
  output logic signed [31:0]    out_return,
  output logic                  last
);
  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_COMPACT, S_APPEND, S_READ, S_RD2}
    state_t;
  state_t state;

  logic signed [31:0] mem_risk [paretoarc_pkg::CAPACITY];
  logic signed [31:0] mem_ret  [paretoarc_pkg::CAPACITY];
  logic [5:0] count;
  logic [5:0] idx;
  logic [5:0] kept;
  logic [5:0] removed;
  logic signed [31:0] cr, cret;
  logic signed [31:0] rd_r, rd_ret;
  logic dom_by, dom_of;

  assign pop  = (state == S_IDLE) && q_valid;
  assign idle = (state == S_IDLE) && !q_valid;

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_r   <= mem_risk[idx[paretoarc_pkg::IDX_W-1:0]];
    rd_ret <= mem_ret[idx[paretoarc_pkg::IDX_W-1:0]];
  end

  assign dom_by = paretoarc_pkg::beats(rd_r, rd_ret, cr, cret, tol) ||
                  (paretoarc_pkg::near_eq(rd_ret, cret, tol) &&
                   paretoarc_pkg::near_eq(rd_r, cr, tol));
  assign dom_of = paretoarc_pkg::beats(cr, cret, rd_r, rd_ret, tol);

  // Sequence one command; idx leads the registered data by one entry.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= 6'd0;
      idx   <= 6'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cr <= q_word.risk;
            cret <= q_word.ret;
            removed_count <= 6'd0;
            out_risk <= '0;
            out_return <= '0;
            last <= 1'b1;
            idx <= 6'd1;
            kept <= 6'd0;
            removed <= 6'd0;
            unique case (q_word.mode)
              paretoarc_pkg::MODE_OFFER: begin
                if (count == 6'd0) state <= S_APPEND;
                else state <= S_CHECK;
                idx <= 6'd0;
              end
              paretoarc_pkg::MODE_READ: begin
                if (count == 6'd0) begin
                  status <= paretoarc_pkg::ST_EMPTY;
                  entry_count <= count;
                  done <= 1'b1;
                end else begin
                  idx <= 6'd0;
                  state <= S_READ;
                end
              end
              paretoarc_pkg::MODE_CLEAR: begin
                count <= 6'd0;
                status <= paretoarc_pkg::ST_EMPTY;
                entry_count <= 6'd0;
                done <= 1'b1;
              end
              default: begin
                status <= paretoarc_pkg::ST_REJECT;
                entry_count <= count;
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          idx <= 6'd1;
          kept <= 6'd0;
          state <= S_RD2;
        end
        S_RD2: begin
          status <= paretoarc_pkg::ST_READOUT;
          entry_count <= count;
          out_risk <= rd_r;
          out_return <= rd_ret;
          last <= (kept + 6'd1 == count);
          done <= 1'b1;
          kept <= kept + 6'd1;
          idx <= idx + 6'd1;
          if (kept + 6'd1 == count) state <= S_IDLE;
        end
        S_CHECK: begin
          // First visit of idx 0 only primes the read; entry idx-1 is in rd_*.
          if (idx != 6'd0) begin
            if (dom_of) removed <= removed + 6'd1;
          end
          if (idx == count) begin
            state <= S_COMPACT;
            idx <= 6'd0;
          end else idx <= idx + 6'd1;
          if (idx != 6'd0 && dom_by) begin
            status <= paretoarc_pkg::ST_REJECT;
            entry_count <= count;
            done <= 1'b1;
            state <= S_IDLE;
          end else if (idx == count && removed == 6'd0 && !dom_of &&
                       count == 6'(paretoarc_pkg::CAPACITY)) begin
            status <= paretoarc_pkg::ST_FULL;
            entry_count <= count;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_COMPACT: begin
          if (idx != 6'd0 && !dom_of) begin
            mem_risk[kept[paretoarc_pkg::IDX_W-1:0]] <= rd_r;
            mem_ret[kept[paretoarc_pkg::IDX_W-1:0]]  <= rd_ret;
            kept <= kept + 6'd1;
          end
          if (idx == count) state <= S_APPEND;
          else idx <= idx + 6'd1;
        end
        S_APPEND: begin
          mem_risk[kept[paretoarc_pkg::IDX_W-1:0]] <= cr;
          mem_ret[kept[paretoarc_pkg::IDX_W-1:0]]  <= cret;
          count <= kept + 6'd1;
          entry_count <= kept + 6'd1;
          removed_count <= removed;
          status <= paretoarc_pkg::ST_ACCEPT;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/pareto_archive_two_objective.sv @@
// Top level: two-objective non-dominated archive with a command queue.
// Offer: dequeue, compare pass and compaction pass over N stored points, then
// append; an empty archive goes from dequeue to append, and a reject or full
// result ends earlier. Readout: dequeue, a registered read, then one word per
// cycle. Clear and unused modes finish at dequeue. Commands wait in a two-word
// queue; results cannot be stalled. Synchronous reset empties the archive, tolerance 1.
`timescale 1ns / 1ps
module pareto_archive_two_objective (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode,
  input  logic signed [31:0]  candidate_risk,
  input  logic signed [31:0]  candidate_return,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output logic                done,
  output logic [2:0]          status,
  output logic [5:0]          removed_count,
  output logic [5:0]          entry_count,
  output logic signed [31:0]  out_risk,
  output logic signed [31:0]  out_return,
  output logic                last
);
  logic [15:0] tolerance;
  logic q_valid, pop, idle;
  paretoarc_pkg::cmd_t q_word;

  // Take a tolerance word only while no command is queued or running.
  assign cfg_ready = idle;

  // Hold the tolerance register.
  always_ff @(posedge clk) begin
    if (rst) tolerance <= 16'd1;
    else if (cfg_valid && cfg_ready) tolerance <= cfg_data;
  end

  paretoarc_front u_front (
    .clk, .rst, .start, .busy, .mode, .candidate_risk, .candidate_return,
    .pop, .q_valid, .q_word
  );

  paretoarc_back u_back (
    .clk, .rst, .tol(tolerance), .idle, .q_valid, .q_word, .pop, .done,
    .status, .removed_count, .entry_count, .out_risk, .out_return, .last
  );
endmodule

@@ rtl/core/paretoarc_checker.sv @@
// Checker: port-level properties of the archive, bound to the top level.
`timescale 1ns / 1ps
module paretoarc_checker (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [2:0]  status,
  input logic [5:0]  removed_count,
  input logic [5:0]  entry_count,
  input logic        last
);
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= paretoarc_pkg::ST_EMPTY) else $error("bad status");
  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= 6'(paretoarc_pkg::CAPACITY)) else $error("bad count");
  a_removed: assert property (@(posedge clk) disable iff (rst)
    done && status != paretoarc_pkg::ST_ACCEPT |-> removed_count == 6'd0)
    else $error("removed on non-accept");
  a_last: assert property (@(posedge clk) disable iff (rst)
    done && status != paretoarc_pkg::ST_READOUT |-> last) else $error("last missing");
endmodule

bind pareto_archive_two_objective paretoarc_checker u_chk (
  .clk, .rst, .done, .status, .removed_count, .entry_count, .last
);
